// ===== rtl/quadric_edge_collapse_cost_macros.svh =====
// Assertion macros shared by the checker files of the edge collapse cost block.
// Depends on nothing; the user supplies clock and reset names in scope.
`ifndef QUADRIC_EDGE_COLLAPSE_COST_MACROS_SVH
`define QUADRIC_EDGE_COLLAPSE_COST_MACROS_SVH

// Same-cycle implication, masked during reset.
`define QECC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define QECC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/qecc_pkg.sv =====
// Shared types, constants, microprogram and fixed-point helpers for the
// quadric edge collapse cost block. Depends on nothing.
package qecc_pkg;

   localparam int FRAC_BITS  = 32;
   localparam int DW         = 64;
   localparam int HALF_W     = DW / 2;
   localparam int TAG_W      = 32;
   localparam int SLOT_W     = 4;
   localparam int EPS_W      = 32;
   localparam int PEN_W      = 41;
   localparam int COST_W     = 63;
   localparam int NUM_Q      = 10;
   localparam int NUM_SLOTS  = 13;
   localparam int NUM_AXES   = 3;
   localparam int QV_IW      = $clog2(NUM_Q);
   localparam int CSR_IDX_W  = 2;
   localparam int RF_DEPTH   = 32;
   localparam int RF_AW      = $clog2(RF_DEPTH);
   localparam int DIV_STEPS  = 2 * DW;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int PROG_LEN   = 84;
   localparam int PC_W       = $clog2(PROG_LEN);

   typedef logic signed [DW-1:0] word_type;
   typedef logic [RF_AW-1:0]     raddr_type;

   localparam word_type WORD_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(DW-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_DET_EPSILON      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDARY_PENALTY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_PENALTY     = 2'd2;

   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
   localparam logic [PEN_W-1:0] BND_PEN_RESET = PEN_W'(64'd100 << FRAC_BITS);
   localparam logic [PEN_W-1:0] LCK_PEN_RESET = PEN_W'(64'd50 << FRAC_BITS);

   // Register file map: summed quadric, endpoint positions, then scratch.
   localparam raddr_type RA_Q0 = 5'd0,  RA_Q1 = 5'd1,  RA_Q2 = 5'd2,  RA_Q3 = 5'd3;
   localparam raddr_type RA_Q4 = 5'd4,  RA_Q5 = 5'd5,  RA_Q6 = 5'd6,  RA_Q7 = 5'd7;
   localparam raddr_type RA_Q8 = 5'd8,  RA_Q9 = 5'd9;
   localparam raddr_type RA_P0 = 5'd10, RA_P1 = 5'd11, RA_P2 = 5'd12;
   localparam raddr_type RA_P3 = 5'd13, RA_P4 = 5'd14, RA_P5 = 5'd15;
   localparam raddr_type RA_C00 = 5'd16, RA_C01 = 5'd17, RA_C02 = 5'd18;
   localparam raddr_type RA_C11 = 5'd19, RA_C12 = 5'd20, RA_C22 = 5'd21;
   localparam raddr_type RA_DET = 5'd22, RA_R0 = 5'd23, RA_R1 = 5'd24, RA_R2 = 5'd25;
   localparam raddr_type RA_X = 5'd26, RA_Y = 5'd27, RA_Z = 5'd28;
   localparam raddr_type RA_T0 = 5'd29, RA_T1 = 5'd30, RA_S = 5'd31;

   typedef enum logic [2:0] {
      OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_NEG, OP_HALF, OP_MOV, OP_SING
   } opc_type;

   typedef enum logic [2:0] {
      CD_ALL, CD_SOLVE, CD_SING, CD_LOCK0, CD_LOCK1
   } cond_type;

   typedef struct packed {
      opc_type   opc;
      cond_type  cond;
      raddr_type dst;
      raddr_type src_a;
      raddr_type src_b;
   } op_type;

   typedef struct packed {
      logic     done;
      word_type value;
   } unit_rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD, ST_ACC, ST_FETCH, ST_EXEC, ST_WAIT_MUL, ST_WAIT_DIV, ST_FINISH
   } state_type;

   localparam op_type PROG [PROG_LEN] = '{
      // cofactors
      '{OP_MUL, CD_ALL, RA_T0, RA_Q4, RA_Q7}, '{OP_MUL, CD_ALL, RA_T1, RA_Q5, RA_Q5},
      '{OP_SUB, CD_ALL, RA_C00, RA_T0, RA_T1},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q2, RA_Q5}, '{OP_MUL, CD_ALL, RA_T1, RA_Q1, RA_Q7},
      '{OP_SUB, CD_ALL, RA_C01, RA_T0, RA_T1},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q1, RA_Q5}, '{OP_MUL, CD_ALL, RA_T1, RA_Q2, RA_Q4},
      '{OP_SUB, CD_ALL, RA_C02, RA_T0, RA_T1},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q0, RA_Q7}, '{OP_MUL, CD_ALL, RA_T1, RA_Q2, RA_Q2},
      '{OP_SUB, CD_ALL, RA_C11, RA_T0, RA_T1},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q1, RA_Q2}, '{OP_MUL, CD_ALL, RA_T1, RA_Q0, RA_Q5},
      '{OP_SUB, CD_ALL, RA_C12, RA_T0, RA_T1},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q0, RA_Q4}, '{OP_MUL, CD_ALL, RA_T1, RA_Q1, RA_Q1},
      '{OP_SUB, CD_ALL, RA_C22, RA_T0, RA_T1},
      // determinant
      '{OP_MUL, CD_ALL, RA_T0, RA_Q0, RA_C00}, '{OP_MUL, CD_ALL, RA_T1, RA_Q1, RA_C01},
      '{OP_ADD, CD_ALL, RA_S, RA_T0, RA_T1}, '{OP_MUL, CD_ALL, RA_T0, RA_Q2, RA_C02},
      '{OP_ADD, CD_ALL, RA_DET, RA_S, RA_T0},
      // right-hand side
      '{OP_NEG, CD_ALL, RA_R0, RA_Q0, RA_Q3}, '{OP_NEG, CD_ALL, RA_R1, RA_Q0, RA_Q6},
      '{OP_NEG, CD_ALL, RA_R2, RA_Q0, RA_Q8},
      '{OP_SING, CD_ALL, RA_Q0, RA_DET, RA_Q0},
      // Cramer solve
      '{OP_MUL, CD_SOLVE, RA_T0, RA_C00, RA_R0}, '{OP_MUL, CD_SOLVE, RA_T1, RA_C01, RA_R1},
      '{OP_ADD, CD_SOLVE, RA_S, RA_T0, RA_T1}, '{OP_MUL, CD_SOLVE, RA_T0, RA_C02, RA_R2},
      '{OP_ADD, CD_SOLVE, RA_S, RA_S, RA_T0}, '{OP_DIV, CD_SOLVE, RA_X, RA_S, RA_DET},
      '{OP_MUL, CD_SOLVE, RA_T0, RA_C01, RA_R0}, '{OP_MUL, CD_SOLVE, RA_T1, RA_C11, RA_R1},
      '{OP_ADD, CD_SOLVE, RA_S, RA_T0, RA_T1}, '{OP_MUL, CD_SOLVE, RA_T0, RA_C12, RA_R2},
      '{OP_ADD, CD_SOLVE, RA_S, RA_S, RA_T0}, '{OP_DIV, CD_SOLVE, RA_Y, RA_S, RA_DET},
      '{OP_MUL, CD_SOLVE, RA_T0, RA_C02, RA_R0}, '{OP_MUL, CD_SOLVE, RA_T1, RA_C12, RA_R1},
      '{OP_ADD, CD_SOLVE, RA_S, RA_T0, RA_T1}, '{OP_MUL, CD_SOLVE, RA_T0, RA_C22, RA_R2},
      '{OP_ADD, CD_SOLVE, RA_S, RA_S, RA_T0}, '{OP_DIV, CD_SOLVE, RA_Z, RA_S, RA_DET},
      // midpoint fallback
      '{OP_HALF, CD_SING, RA_X, RA_P0, RA_P3}, '{OP_HALF, CD_SING, RA_Y, RA_P1, RA_P4},
      '{OP_HALF, CD_SING, RA_Z, RA_P2, RA_P5},
      // lone locked endpoint
      '{OP_MOV, CD_LOCK0, RA_X, RA_P0, RA_Q0}, '{OP_MOV, CD_LOCK0, RA_Y, RA_P1, RA_Q0},
      '{OP_MOV, CD_LOCK0, RA_Z, RA_P2, RA_Q0},
      '{OP_MOV, CD_LOCK1, RA_X, RA_P3, RA_Q0}, '{OP_MOV, CD_LOCK1, RA_Y, RA_P4, RA_Q0},
      '{OP_MOV, CD_LOCK1, RA_Z, RA_P5, RA_Q0},
      // error v'Qv
      '{OP_MUL, CD_ALL, RA_T0, RA_Q0, RA_X}, '{OP_MUL, CD_ALL, RA_S, RA_T0, RA_X},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q1, RA_X}, '{OP_MUL, CD_ALL, RA_T0, RA_T0, RA_Y},
      '{OP_ADD, CD_ALL, RA_T0, RA_T0, RA_T0}, '{OP_ADD, CD_ALL, RA_S, RA_S, RA_T0},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q2, RA_X}, '{OP_MUL, CD_ALL, RA_T0, RA_T0, RA_Z},
      '{OP_ADD, CD_ALL, RA_T0, RA_T0, RA_T0}, '{OP_ADD, CD_ALL, RA_S, RA_S, RA_T0},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q3, RA_X}, '{OP_ADD, CD_ALL, RA_T0, RA_T0, RA_T0},
      '{OP_ADD, CD_ALL, RA_S, RA_S, RA_T0},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q4, RA_Y}, '{OP_MUL, CD_ALL, RA_T0, RA_T0, RA_Y},
      '{OP_ADD, CD_ALL, RA_S, RA_S, RA_T0},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q5, RA_Y}, '{OP_MUL, CD_ALL, RA_T0, RA_T0, RA_Z},
      '{OP_ADD, CD_ALL, RA_T0, RA_T0, RA_T0}, '{OP_ADD, CD_ALL, RA_S, RA_S, RA_T0},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q6, RA_Y}, '{OP_ADD, CD_ALL, RA_T0, RA_T0, RA_T0},
      '{OP_ADD, CD_ALL, RA_S, RA_S, RA_T0},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q7, RA_Z}, '{OP_MUL, CD_ALL, RA_T0, RA_T0, RA_Z},
      '{OP_ADD, CD_ALL, RA_S, RA_S, RA_T0},
      '{OP_MUL, CD_ALL, RA_T0, RA_Q8, RA_Z}, '{OP_ADD, CD_ALL, RA_T0, RA_T0, RA_T0},
      '{OP_ADD, CD_ALL, RA_S, RA_S, RA_T0},
      '{OP_ADD, CD_ALL, RA_S, RA_S, RA_Q9}
   };

   function automatic logic [DW-1:0] mag_of(input word_type v);
      logic [DW-1:0] u;
      u = v;
      return v[DW-1] ? (~u + 1'b1) : u;
   endfunction

   function automatic word_type from_mag(input logic [DW-1:0] m, input logic neg);
      word_type r;
      if (neg) begin
         r = m[DW-1] ? WORD_MIN : word_type'(~m + 1'b1);
      end else begin
         r = m[DW-1] ? WORD_MAX : word_type'(m);
      end
      return r;
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      return (s[DW] != s[DW-1]) ? (s[DW] ? WORD_MIN : WORD_MAX) : word_type'(s[DW-1:0]);
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic [DW:0] s;
      s = {a[DW-1], a} - {b[DW-1], b};
      return (s[DW] != s[DW-1]) ? (s[DW] ? WORD_MIN : WORD_MAX) : word_type'(s[DW-1:0]);
   endfunction

   // Floor average without overflow.
   function automatic word_type half_sum(input word_type a, input word_type b);
      logic [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      return word_type'(s[DW:1]);
   endfunction

endpackage

// ===== rtl/qecc_if.sv =====
// Handshake channels of the edge collapse cost block: request, response and
// register write. Depends on qecc_pkg.
interface qecc_req_if;
   import qecc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [TAG_W-1:0]        edge_tag;
   logic                    endpoint;
   logic [SLOT_W-1:0]       slot;
   logic signed [DW-1:0]    value;
   logic                    endpoint_locked;
   logic                    edge_boundary;
   logic                    last;
   modport source (output valid, edge_tag, endpoint, slot, value, endpoint_locked,
                   edge_boundary, last, input ready);
   modport sink   (input valid, edge_tag, endpoint, slot, value, endpoint_locked,
                   edge_boundary, last, output ready);
endinterface

interface qecc_rsp_if;
   import qecc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [TAG_W-1:0]        tag_out;
   logic                    collapse_valid;
   logic                    keep_second;
   logic                    used_midpoint;
   logic signed [DW-1:0]    pos_x;
   logic signed [DW-1:0]    pos_y;
   logic signed [DW-1:0]    pos_z;
   logic [COST_W-1:0]       cost;
   modport source (output valid, tag_out, collapse_valid, keep_second, used_midpoint,
                   pos_x, pos_y, pos_z, cost, input ready);
   modport sink   (input valid, tag_out, collapse_valid, keep_second, used_midpoint,
                   pos_x, pos_y, pos_z, cost, output ready);
endinterface

interface qecc_csr_if;
   import qecc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_W-1:0]    index;
   logic [PEN_W-1:0]        data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/qecc_regfile.sv =====
// Working store: one write port, two registered read ports.
// Depends on qecc_pkg.
module qecc_regfile (
   input  logic                 clock,
   input  logic                 we,
   input  qecc_pkg::raddr_type  waddr,
   input  qecc_pkg::word_type   wdata,
   input  qecc_pkg::raddr_type  raddr_a,
   input  qecc_pkg::raddr_type  raddr_b,
   output qecc_pkg::word_type   rdata_a,
   output qecc_pkg::word_type   rdata_b
);
   import qecc_pkg::*;

   word_type mem [RF_DEPTH];
   word_type rdata_a_ff, rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;
endmodule

// ===== rtl/qecc_mul.sv =====
// Fixed-point multiplier: four 32x32 partial products accumulated in turn,
// then round, scale and saturate. Depends on qecc_pkg.
module qecc_mul (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  qecc_pkg::word_type      op_a,
   input  qecc_pkg::word_type      op_b,
   output qecc_pkg::unit_rsp_type  rsp
);
   import qecc_pkg::*;

   logic [DW-1:0]   xm_ff, xm_in, ym_ff, ym_in;
   logic            neg_ff, neg_in;
   logic [2*DW-1:0] acc_ff, acc_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            run_ff, run_in, fin_ff, fin_in, done_ff, done_in;
   word_type        prod_ff, prod_in;
   logic [HALF_W-1:0] x_half, y_half;
   logic [DW-1:0]   pp;
   logic [2*DW-1:0] pp_sh, rnd, scaled;
   logic [DW-1:0]   m;

   always_comb begin
      x_half = cnt_ff[1] ? xm_ff[DW-1:HALF_W] : xm_ff[HALF_W-1:0];
      y_half = cnt_ff[0] ? ym_ff[DW-1:HALF_W] : ym_ff[HALF_W-1:0];
      pp     = x_half * y_half;
      unique case (cnt_ff)
         2'd0:    pp_sh = (2*DW)'(pp);
         2'd3:    pp_sh = (2*DW)'(pp) << DW;
         default: pp_sh = (2*DW)'(pp) << HALF_W;
      endcase
      rnd    = acc_ff + ((2*DW)'(1) << (FRAC_BITS - 1));
      scaled = rnd >> FRAC_BITS;
      m      = (|scaled[2*DW-1:DW]) ? {DW{1'b1}} : scaled[DW-1:0];

      xm_in   = xm_ff;
      ym_in   = ym_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      prod_in = prod_ff;
      if (start) begin
         xm_in  = mag_of(op_a);
         ym_in  = mag_of(op_b);
         neg_in = op_a[DW-1] ^ op_b[DW-1];
         acc_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = acc_ff + pp_sh;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
      if (fin_ff) begin
         prod_in = from_mag(m, neg_ff);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      xm_ff   <= xm_in;
      ym_ff   <= ym_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = prod_ff;
endmodule

// ===== rtl/qecc_div.sv =====
// Fixed-point divider: restoring, one quotient bit a cycle over the scaled
// 128-bit dividend, then saturate. Depends on qecc_pkg.
module qecc_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  qecc_pkg::word_type      num,
   input  qecc_pkg::word_type      den,
   output qecc_pkg::unit_rsp_type  rsp
);
   import qecc_pkg::*;

   logic [2*DW-1:0]      dvd_ff, dvd_in, quo_ff, quo_in;
   logic [DW-1:0]        rem_ff, rem_in, dm_ff, dm_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in, zero_ff, zero_in;
   logic                 run_ff, run_in, fin_ff, fin_in, done_ff, done_in;
   word_type             quot_ff, quot_in;
   logic [DW:0]          trial, diff;
   logic                 qbit;
   logic [DW-1:0]        m;

   always_comb begin
      trial = {rem_ff, dvd_ff[2*DW-1]};
      diff  = trial - {1'b0, dm_ff};
      qbit  = trial >= {1'b0, dm_ff};
      m     = (|quo_ff[2*DW-1:DW]) ? {DW{1'b1}} : quo_ff[DW-1:0];

      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dm_in   = dm_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      quot_in = quot_ff;
      if (start) begin
         dvd_in  = (2*DW)'(mag_of(num)) << FRAC_BITS;
         dm_in   = mag_of(den);
         zero_in = (den == '0);
         neg_in  = num[DW-1] ^ den[DW-1];
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in = qbit ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[2*DW-2:0], qbit};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
      if (fin_ff) begin
         quot_in = zero_ff ? '0 : from_mag(m, neg_ff);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dm_ff   <= dm_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      quot_ff <= quot_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = quot_ff;
endmodule

// ===== rtl/quadric_edge_collapse_cost.sv =====
// Quadric edge collapse cost unit. An edge arrives as request words (quadric
// coefficients and endpoint positions); each word is stored through the load
// and accumulate states. The word marked last starts an 84-step microprogram
// that runs every operation through one shared four-pass multiplier, one
// 128-step divider and a saturating adder; the cofactors, determinant and
// error always run, and the Cramer solve runs only when the determinant is
// not judged singular. When both endpoints are locked the program is skipped.
// The request side stays not ready until the result moves to the output
// register. A finished result waits in an output register while the next
// edge loads; a second result holds the block until the first is taken.
module quadric_edge_collapse_cost (
   input  logic        clock,
   input  logic        reset,
   qecc_req_if.sink    req_if,
   qecc_rsp_if.source  rsp_if,
   qecc_csr_if.sink    csr_if
);
   import qecc_pkg::*;

   state_type         state_ff, state_in;
   logic [EPS_W-1:0]  eps_ff, eps_in;
   logic [PEN_W-1:0]  bpen_ff, bpen_in, lpen_ff, lpen_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              ep_ff, ep_in, last_ff, last_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   word_type          value_ff, value_in;
   logic [1:0]        lock_ff, lock_in;
   logic              bnd_ff, bnd_in, sing_ff, sing_in;
   logic [NUM_Q-1:0]  qv_ff, qv_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   word_type          res_ff, res_in, px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic              zero_a_ff, zero_a_in, zero_b_ff, zero_b_in;

   logic              out_valid_ff, out_valid_in, out_cv_ff, out_cv_in;
   logic              out_keep_ff, out_keep_in, out_mid_ff, out_mid_in;
   logic [TAG_W-1:0]  out_tag_ff, out_tag_in;
   word_type          out_px_ff, out_px_in, out_py_ff, out_py_in, out_pz_ff, out_pz_in;
   logic [COST_W-1:0] out_cost_ff, out_cost_in;

   logic              rf_we;
   raddr_type         rf_waddr, rf_raddr_a, rf_raddr_b;
   word_type          rf_wdata, rf_rdata_a, rf_rdata_b;
   logic              mul_start, div_start;
   unit_rsp_type      mul_rsp, div_rsp;

   op_type            op;
   logic              cond_ok, last_op, req_take, fin_move, edge_ok;
   word_type          opa, opb, alu_res, wb_val;
   logic              wb_en;
   logic [DW-1:0]     cost_sum;
   logic [COST_W-1:0] cost_val;

   qecc_regfile u_rf (
      .clock   (clock),
      .we      (rf_we),
      .waddr   (rf_waddr),
      .wdata   (rf_wdata),
      .raddr_a (rf_raddr_a),
      .raddr_b (rf_raddr_b),
      .rdata_a (rf_rdata_a),
      .rdata_b (rf_rdata_b)
   );

   qecc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (opa),
      .op_b  (opb),
      .rsp   (mul_rsp)
   );

   qecc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (opa),
      .den   (opb),
      .rsp   (div_rsp)
   );

   assign op       = PROG[pc_ff];
   assign last_op  = (pc_ff == PC_W'(PROG_LEN - 1));
   assign opa      = zero_a_ff ? '0 : rf_rdata_a;
   assign opb      = zero_b_ff ? '0 : rf_rdata_b;
   assign req_take = req_if.valid && (state_ff == ST_LOAD);
   assign fin_move = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_if.ready);
   assign edge_ok  = !(lock_ff[0] && lock_ff[1]);

   always_comb begin
      unique case (op.cond)
         CD_ALL:   cond_ok = 1'b1;
         CD_SOLVE: cond_ok = !sing_ff;
         CD_SING:  cond_ok = sing_ff;
         CD_LOCK0: cond_ok = lock_ff[0];
         CD_LOCK1: cond_ok = lock_ff[1] && !lock_ff[0];
         default:  cond_ok = 1'b0;
      endcase
   end

   always_comb begin
      unique case (op.opc)
         OP_ADD:  alu_res = sat_add(opa, opb);
         OP_SUB:  alu_res = sat_sub(opa, opb);
         OP_NEG:  alu_res = sat_sub('0, opb);
         OP_HALF: alu_res = half_sum(opa, opb);
         default: alu_res = opa;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) state_in = ST_ACC;
         end
         ST_ACC: begin
            if (last_ff) state_in = edge_ok ? ST_FETCH : ST_FINISH;
            else         state_in = ST_LOAD;
         end
         ST_FETCH: begin
            if (cond_ok)      state_in = ST_EXEC;
            else if (last_op) state_in = ST_FINISH;
         end
         ST_EXEC: begin
            priority if (op.opc == OP_MUL) state_in = ST_WAIT_MUL;
            else if (op.opc == OP_DIV)     state_in = ST_WAIT_DIV;
            else                           state_in = last_op ? ST_FINISH : ST_FETCH;
         end
         ST_WAIT_MUL: begin
            if (mul_rsp.done) state_in = last_op ? ST_FINISH : ST_FETCH;
         end
         ST_WAIT_DIV: begin
            if (div_rsp.done) state_in = last_op ? ST_FINISH : ST_FETCH;
         end
         ST_FINISH: begin
            if (fin_move) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Datapath control
   always_comb begin
      eps_in   = eps_ff;
      bpen_in  = bpen_ff;
      lpen_in  = lpen_ff;
      tag_in   = tag_ff;
      ep_in    = ep_ff;
      slot_in  = slot_ff;
      value_in = value_ff;
      last_in  = last_ff;
      lock_in  = lock_ff;
      bnd_in   = bnd_ff;
      sing_in  = sing_ff;
      qv_in    = qv_ff;
      pc_in    = pc_ff;
      res_in   = res_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pz_in    = pz_ff;
      rf_we      = 1'b0;
      rf_waddr   = op.dst;
      rf_wdata   = alu_res;
      rf_raddr_a = op.src_a;
      rf_raddr_b = op.src_b;
      mul_start  = 1'b0;
      div_start  = 1'b0;
      wb_en      = 1'b0;
      wb_val     = alu_res;

      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_DET_EPSILON:      eps_in  = csr_if.data[EPS_W-1:0];
            CSR_BOUNDARY_PENALTY: bpen_in = csr_if.data;
            CSR_LOCK_PENALTY:     lpen_in = csr_if.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_LOAD: begin
            rf_raddr_a = raddr_type'(req_if.slot);
            if (req_take) begin
               tag_in   = req_if.edge_tag;
               ep_in    = req_if.endpoint;
               slot_in  = req_if.slot;
               value_in = req_if.value;
               last_in  = req_if.last;
               if (req_if.endpoint_locked) lock_in[req_if.endpoint] = 1'b1;
               if (req_if.edge_boundary)   bnd_in = 1'b1;
            end
         end
         ST_ACC: begin
            // Accumulate a coefficient, overwrite a coordinate, ignore the rest
            pc_in = '0;
            if (slot_ff < SLOT_W'(NUM_Q)) begin
               rf_we    = 1'b1;
               rf_waddr = raddr_type'(slot_ff);
               rf_wdata = sat_add(opa, value_ff);
               qv_in[slot_ff[QV_IW-1:0]] = 1'b1;
            end else if (slot_ff < SLOT_W'(NUM_SLOTS)) begin
               rf_we    = 1'b1;
               rf_waddr = raddr_type'(slot_ff) + (ep_ff ? raddr_type'(NUM_AXES) : '0);
               rf_wdata = value_ff;
            end
         end
         ST_FETCH: begin
            if (!cond_ok) pc_in = pc_ff + 1'b1;
         end
         ST_EXEC: begin
            priority if (op.opc == OP_MUL) begin
               mul_start = 1'b1;
            end else if (op.opc == OP_DIV) begin
               div_start = 1'b1;
            end else if (op.opc == OP_SING) begin
               sing_in = (opa == '0) || (mag_of(opa) < DW'(eps_ff));
               pc_in   = pc_ff + 1'b1;
            end else begin
               wb_en = 1'b1;
               pc_in = pc_ff + 1'b1;
            end
         end
         ST_WAIT_MUL: begin
            wb_val = mul_rsp.value;
            if (mul_rsp.done) begin
               wb_en = 1'b1;
               pc_in = pc_ff + 1'b1;
            end
         end
         ST_WAIT_DIV: begin
            wb_val = div_rsp.value;
            if (div_rsp.done) begin
               wb_en = 1'b1;
               pc_in = pc_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // Drop the edge state once the result is handed over
            if (fin_move) begin
               qv_in   = '0;
               lock_in = '0;
               bnd_in  = 1'b0;
            end
         end
         default: ;
      endcase

      if (wb_en) begin
         rf_we    = 1'b1;
         rf_waddr = op.dst;
         rf_wdata = wb_val;
         res_in   = wb_val;
         if (op.dst == RA_X) px_in = wb_val;
         if (op.dst == RA_Y) py_in = wb_val;
         if (op.dst == RA_Z) pz_in = wb_val;
      end

      zero_a_in = (rf_raddr_a < raddr_type'(NUM_Q)) && !qv_ff[rf_raddr_a[QV_IW-1:0]];
      zero_b_in = (rf_raddr_b < raddr_type'(NUM_Q)) && !qv_ff[rf_raddr_b[QV_IW-1:0]];
   end

   // Result assembly
   always_comb begin
      cost_sum = (res_ff[DW-1] ? '0 : DW'(res_ff[DW-2:0]))
               + (bnd_ff ? DW'(bpen_ff) : '0)
               + ((lock_ff[0] || lock_ff[1]) ? DW'(lpen_ff) : '0);
      cost_val = cost_sum[DW-1] ? {COST_W{1'b1}} : cost_sum[COST_W-1:0];

      out_tag_in  = out_tag_ff;
      out_cv_in   = out_cv_ff;
      out_keep_in = out_keep_ff;
      out_mid_in  = out_mid_ff;
      out_px_in   = out_px_ff;
      out_py_in   = out_py_ff;
      out_pz_in   = out_pz_ff;
      out_cost_in = out_cost_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      if (fin_move) begin
         out_valid_in = 1'b1;
         out_tag_in   = tag_ff;
         out_cv_in    = edge_ok;
         out_keep_in  = edge_ok && lock_ff[1] && !lock_ff[0];
         out_mid_in   = edge_ok && sing_ff && !lock_ff[0] && !lock_ff[1];
         out_px_in    = edge_ok ? px_ff : '0;
         out_py_in    = edge_ok ? py_ff : '0;
         out_pz_in    = edge_ok ? pz_ff : '0;
         out_cost_in  = edge_ok ? cost_val : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         eps_ff       <= EPS_RESET;
         bpen_ff      <= BND_PEN_RESET;
         lpen_ff      <= LCK_PEN_RESET;
         lock_ff      <= '0;
         bnd_ff       <= 1'b0;
         sing_ff      <= 1'b0;
         qv_ff        <= '0;
         pc_ff        <= '0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eps_ff       <= eps_in;
         bpen_ff      <= bpen_in;
         lpen_ff      <= lpen_in;
         lock_ff      <= lock_in;
         bnd_ff       <= bnd_in;
         sing_ff      <= sing_in;
         qv_ff        <= qv_in;
         pc_ff        <= pc_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
      tag_ff      <= tag_in;
      ep_ff       <= ep_in;
      slot_ff     <= slot_in;
      value_ff    <= value_in;
      res_ff      <= res_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      zero_a_ff   <= zero_a_in;
      zero_b_ff   <= zero_b_in;
      out_tag_ff  <= out_tag_in;
      out_cv_ff   <= out_cv_in;
      out_keep_ff <= out_keep_in;
      out_mid_ff  <= out_mid_in;
      out_px_ff   <= out_px_in;
      out_py_ff   <= out_py_in;
      out_pz_ff   <= out_pz_in;
      out_cost_ff <= out_cost_in;
   end

   assign req_if.ready          = (state_ff == ST_LOAD);
   assign csr_if.ready          = 1'b1;
   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.tag_out        = out_tag_ff;
   assign rsp_if.collapse_valid = out_cv_ff;
   assign rsp_if.keep_second    = out_keep_ff;
   assign rsp_if.used_midpoint  = out_mid_ff;
   assign rsp_if.pos_x          = out_px_ff;
   assign rsp_if.pos_y          = out_py_ff;
   assign rsp_if.pos_z          = out_pz_ff;
   assign rsp_if.cost           = out_cost_ff;
endmodule

// ===== rtl/qecc_checker.sv =====
// Port-level checks of the edge collapse cost block and their binding.
// Depends on qecc_pkg and the assertion macro header.
`include "quadric_edge_collapse_cost_macros.svh"

module qecc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_collapse_valid,
   input logic                        rsp_keep_second,
   input logic                        rsp_used_midpoint,
   input logic [qecc_pkg::DW-1:0]     rsp_pos_x,
   input logic [qecc_pkg::COST_W-1:0] rsp_cost
);
   import qecc_pkg::*;

   `QECC_ASSERT_NEXT(a_busy_after_last, req_valid && req_ready && req_last, !req_ready, "request taken after last word")
   `QECC_ASSERT_IMPL(a_invalid_zero, rsp_valid && !rsp_collapse_valid, rsp_cost == '0 && rsp_pos_x == '0 && !rsp_keep_second, "locked edge result not zero")
   `QECC_ASSERT_IMPL(a_keep_excl, rsp_valid && rsp_keep_second, rsp_collapse_valid && !rsp_used_midpoint, "kept endpoint with midpoint")
   `QECC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
endmodule

bind quadric_edge_collapse_cost qecc_checker u_qecc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .req_last           (req_if.last),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_collapse_valid (rsp_if.collapse_valid),
   .rsp_keep_second    (rsp_if.keep_second),
   .rsp_used_midpoint  (rsp_if.used_midpoint),
   .rsp_pos_x          (rsp_if.pos_x),
   .rsp_cost           (rsp_if.cost)
);

// ===== tb/tb.sv =====
// Self-checking bench for quadric_edge_collapse_cost: directed table, then random edges.
// Depends on qecc_pkg, the qecc channel interfaces and the block itself.
`timescale 1ns / 100ps

module tb;
   import qecc_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOLD_CYCLES    = 3000;
   localparam int PHASE_WORDS    = 500;
   localparam logic signed [63:0] FX_ONE = 64'sh0000_0001_0000_0000;

   typedef struct packed {
      logic [31:0]        tag;
      logic               ep;
      logic [3:0]         slot;
      logic signed [63:0] value;
      logic               locked;
      logic               boundary;
      logic               last;
   } edge_word_type;

   typedef struct packed {
      logic [31:0]        tag;
      logic               cvalid;
      logic               keep2;
      logic               midp;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic [62:0]        cost;
   } collapse_type;

   typedef struct packed {
      edge_word_type w;
      logic          typed;
      collapse_type  e;
   } dir_row_type;

   localparam collapse_type NO_EXP = '0;

   localparam dir_row_type DIR_TAB [23] = '{
      '{'{32'd1, 1'b0, 4'd10, 64'sh0000_0001_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd1, 1'b0, 4'd11, 64'sh0000_0002_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd1, 1'b0, 4'd12, 64'sh0000_0003_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd1, 1'b1, 4'd10, 64'sh0000_0003_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd1, 1'b1, 4'd11, 64'shFFFF_FFFE_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd1, 1'b1, 4'd12, 64'sh0000_0005_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      // zero quadric: singular, midpoint
      '{'{32'd1, 1'b0, 4'd0, 64'sh0, 1'b0, 1'b0, 1'b1}, 1'b1,
        '{32'd1, 1'b1, 1'b0, 1'b1, 64'sh0000_0002_0000_0000, 64'sh0,
          64'sh0000_0004_0000_0000, 63'h0}},
      // first endpoint locked, unused slot
      '{'{32'hFFFF_FFFF, 1'b0, 4'd13, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1}, 1'b1,
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 64'sh0000_0001_0000_0000,
          64'sh0000_0002_0000_0000, 64'sh0000_0003_0000_0000, 63'h32_0000_0000}},
      // second endpoint locked on a boundary edge
      '{'{32'd2, 1'b1, 4'd14, 64'sh8000_0000_0000_0000, 1'b1, 1'b1, 1'b1}, 1'b1,
        '{32'd2, 1'b1, 1'b1, 1'b0, 64'sh0000_0003_0000_0000,
          64'shFFFF_FFFE_0000_0000, 64'sh0000_0005_0000_0000, 63'h96_0000_0000}},
      // both locked
      '{'{32'd3, 1'b0, 4'd15, 64'sh0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd3, 1'b1, 4'd15, 64'sh0, 1'b1, 1'b0, 1'b1}, 1'b1,
        '{32'd3, 1'b0, 1'b0, 1'b0, 64'sh0, 64'sh0, 64'sh0, 63'h0}},
      '{'{32'd4, 1'b0, 4'd0, 64'sh0000_0001_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd4, 1'b1, 4'd4, 64'sh0000_0001_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd4, 1'b0, 4'd7, 64'sh0000_0001_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd4, 1'b0, 4'd3, 64'sh8000_0000_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd4, 1'b1, 4'd6, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd4, 1'b0, 4'd9, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b1}, 1'b0, NO_EXP},
      '{'{32'd5, 1'b0, 4'd0, 64'sh8000_0000_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd5, 1'b1, 4'd0, 64'sh8000_0000_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd5, 1'b0, 4'd4, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd5, 1'b1, 4'd7, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1}, 1'b0, NO_EXP},
      '{'{32'd6, 1'b0, 4'd8, 64'shFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0}, 1'b0, NO_EXP},
      '{'{32'd6, 1'b0, 4'd5, 64'sh0000_0000_0000_0001, 1'b0, 1'b0, 1'b1}, 1'b0, NO_EXP}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   qecc_req_if req ();
   qecc_rsp_if rsp ();
   qecc_csr_if csr ();

   quadric_edge_collapse_cost uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic signed [63:0] acc_q [10];
   logic signed [63:0] end_pos [6];
   logic [1:0]         lock_acc;
   logic               bnd_acc;
   logic [31:0]        eps_reg;
   logic [40:0]        bnd_pen;
   logic [40:0]        lck_pen;

   collapse_type exp_q [$];
   int           fails = 0;
   int           tx_idle_pct = 0;
   int           rx_idle_pct = 0;
   bit           hold_rx = 1'b0;
   int           quiet_cycles = 0;

   function automatic logic [63:0] fx_mag(input logic signed [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   function automatic logic signed [63:0] fx_signed(input logic [63:0] m, input logic neg);
      if (neg) return m[63] ? 64'sh8000_0000_0000_0000 : -$signed(m);
      return m[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(m);
   endfunction

   function automatic logic signed [63:0] fx_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return s;
   endfunction

   function automatic logic signed [63:0] fx_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63])
         return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return s;
   endfunction

   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic [127:0] p;
      logic [63:0]  r;
      p = {64'd0, fx_mag(a)} * {64'd0, fx_mag(b)};
      p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      r = (p[127:64] != 0) ? '1 : p[63:0];
      return fx_signed(r, a[63] ^ b[63]);
   endfunction

   function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                  input logic signed [63:0] d);
      logic [127:0] q;
      logic [63:0]  r;
      if (d == 0) return 64'sh0;
      q = ({64'd0, fx_mag(n)} << FRAC_BITS) / {64'd0, fx_mag(d)};
      r = (q[127:64] != 0) ? '1 : q[63:0];
      return fx_signed(r, n[63] ^ d[63]);
   endfunction

   function automatic logic signed [63:0] fx_mid(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      return s[64:1];
   endfunction

   function automatic logic signed [63:0] fx_dbl(input logic signed [63:0] t);
      return fx_add(t, t);
   endfunction

   // Absorb one word; returns 1 with the collapse result on the last word.
   function automatic bit collapse_step(input edge_word_type w, output collapse_type r);
      logic signed [63:0] c00, c01, c02, c11, c12, c22, dtm, r0, r1, r2, err;
      logic signed [63:0] px, py, pz;
      logic [63:0]        total;
      bit                 sing;
      r = '0;
      if (w.slot < 10) acc_q[w.slot] = fx_add(acc_q[w.slot], w.value);
      else if (w.slot < 13) end_pos[w.ep * 3 + (w.slot - 10)] = w.value;
      if (w.locked) lock_acc[w.ep] = 1'b1;
      if (w.boundary) bnd_acc = 1'b1;
      if (!w.last) return 1'b0;
      r.tag = w.tag;
      r.cvalid = !(lock_acc[0] && lock_acc[1]);
      if (r.cvalid) begin
         c00 = fx_sub(fx_mul(acc_q[4], acc_q[7]), fx_mul(acc_q[5], acc_q[5]));
         c01 = fx_sub(fx_mul(acc_q[2], acc_q[5]), fx_mul(acc_q[1], acc_q[7]));
         c02 = fx_sub(fx_mul(acc_q[1], acc_q[5]), fx_mul(acc_q[2], acc_q[4]));
         c11 = fx_sub(fx_mul(acc_q[0], acc_q[7]), fx_mul(acc_q[2], acc_q[2]));
         c12 = fx_sub(fx_mul(acc_q[1], acc_q[2]), fx_mul(acc_q[0], acc_q[5]));
         c22 = fx_sub(fx_mul(acc_q[0], acc_q[4]), fx_mul(acc_q[1], acc_q[1]));
         dtm = fx_add(fx_add(fx_mul(acc_q[0], c00), fx_mul(acc_q[1], c01)),
                      fx_mul(acc_q[2], c02));
         r0 = fx_sub(0, acc_q[3]);
         r1 = fx_sub(0, acc_q[6]);
         r2 = fx_sub(0, acc_q[8]);
         sing = (dtm == 0) || (fx_mag(dtm) < {32'd0, eps_reg});
         if (sing) begin
            px = fx_mid(end_pos[0], end_pos[3]);
            py = fx_mid(end_pos[1], end_pos[4]);
            pz = fx_mid(end_pos[2], end_pos[5]);
         end else begin
            px = fx_div(fx_add(fx_add(fx_mul(c00, r0), fx_mul(c01, r1)), fx_mul(c02, r2)), dtm);
            py = fx_div(fx_add(fx_add(fx_mul(c01, r0), fx_mul(c11, r1)), fx_mul(c12, r2)), dtm);
            pz = fx_div(fx_add(fx_add(fx_mul(c02, r0), fx_mul(c12, r1)), fx_mul(c22, r2)), dtm);
         end
         if (lock_acc[0]) begin
            px = end_pos[0]; py = end_pos[1]; pz = end_pos[2];
         end else if (lock_acc[1]) begin
            px = end_pos[3]; py = end_pos[4]; pz = end_pos[5];
            r.keep2 = 1'b1;
         end else begin
            r.midp = sing;
         end
         err = fx_mul(fx_mul(acc_q[0], px), px);
         err = fx_add(err, fx_dbl(fx_mul(fx_mul(acc_q[1], px), py)));
         err = fx_add(err, fx_dbl(fx_mul(fx_mul(acc_q[2], px), pz)));
         err = fx_add(err, fx_dbl(fx_mul(acc_q[3], px)));
         err = fx_add(err, fx_mul(fx_mul(acc_q[4], py), py));
         err = fx_add(err, fx_dbl(fx_mul(fx_mul(acc_q[5], py), pz)));
         err = fx_add(err, fx_dbl(fx_mul(acc_q[6], py)));
         err = fx_add(err, fx_mul(fx_mul(acc_q[7], pz), pz));
         err = fx_add(err, fx_dbl(fx_mul(acc_q[8], pz)));
         err = fx_add(err, acc_q[9]);
         total = err[63] ? 64'd0 : err;
         if (bnd_acc) total = total + bnd_pen;
         if (lock_acc != 2'b00) total = total + lck_pen;
         if (total[63]) total = {1'b0, {63{1'b1}}};
         r.x = px; r.y = py; r.z = pz;
         r.cost = total[62:0];
      end
      foreach (acc_q[k]) acc_q[k] = 0;
      lock_acc = 2'b00;
      bnd_acc = 1'b0;
      return 1'b1;
   endfunction

   task automatic send_word(input edge_word_type w, input bit typed, input collapse_type e);
      collapse_type r;
      int           gap;
      if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         gap = $urandom_range(6, 1);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid           <= 1'b1;
      req.edge_tag        <= w.tag;
      req.endpoint        <= w.ep;
      req.slot            <= w.slot;
      req.value           <= w.value;
      req.endpoint_locked <= w.locked;
      req.edge_boundary   <= w.boundary;
      req.last            <= w.last;
      do @(posedge clock); while (!req.ready);
      if (collapse_step(w, r)) exp_q = {exp_q, (typed ? e : r)};
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (exp_q.size() != 0) @(posedge clock);
      // let trailing non-last words settle
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PEN_W-1:0] data);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= data;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      case (idx)
         CSR_DET_EPSILON:      eps_reg = data[31:0];
         CSR_BOUNDARY_PENALTY: bnd_pen = data;
         CSR_LOCK_PENALTY:     lck_pen = data;
         default: ;
      endcase
   endtask

   function automatic logic signed [63:0] pick_value(input int cls, input logic [3:0] slot);
      logic signed [63:0] v;
      v = $signed({$urandom, $urandom});
      case (cls)
         0: v = v >>> 28;
         1: ;
         2: case ($urandom_range(5))
               0: v = 64'sh8000_0000_0000_0000;
               1: v = 64'sh7FFF_FFFF_FFFF_FFFF;
               2: v = 64'sh0;
               3: v = 64'sh1;
               4: v = -64'sh1;
               default: v = FX_ONE;
            endcase
         default: v = (slot < 9) ? 64'sh0 : (v >>> 28);
      endcase
      return v;
   endfunction

   task automatic send_random_edge(inout int words);
      edge_word_type ws [26];
      edge_word_type tmp;
      logic [31:0] tag;
      int cls, n, j, kind;
      bit lk0, lk1, bnd;
      tag = $urandom;
      kind = $urandom_range(99);
      lk0 = $urandom_range(99) < 15;
      lk1 = $urandom_range(99) < 15;
      bnd = $urandom_range(99) < 30;
      if (kind < 10) begin
         // broken edge: a few loose words of any slot
         n = $urandom_range(8, 1);
         for (int i = 0; i < n; i++) begin
            ws[i] = {$urandom, 1'b0, 4'(0), 64'sh0, 3'b000};
            ws[i].ep = $urandom_range(1);
            ws[i].slot = $urandom_range(15);
            ws[i].value = pick_value($urandom_range(3), ws[i].slot);
            ws[i].locked = $urandom_range(99) < 10;
            ws[i].boundary = $urandom_range(1);
            ws[i].last = (i == n - 1) ? $urandom_range(1) : 1'b0;
         end
      end else begin
         cls = (kind < 65) ? 0 : (kind < 77) ? 1 : (kind < 87) ? 2 : 3;
         n = 26;
         for (int i = 0; i < 26; i++) begin
            ws[i].tag = tag;
            ws[i].ep = i / 13;
            ws[i].slot = i % 13;
            ws[i].value = pick_value(cls, ws[i].slot);
            ws[i].locked = ws[i].ep ? lk1 : lk0;
            ws[i].boundary = bnd && $urandom_range(1);
            ws[i].last = 1'b0;
         end
         for (int i = 25; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = ws[i]; ws[i] = ws[j]; ws[j] = tmp;
         end
         ws[25].last = 1'b1;
         ws[25].boundary = bnd;
      end
      for (int i = 0; i < n; i++) begin
         send_word(ws[i], 1'b0, NO_EXP);
         words++;
      end
   endtask

   task automatic run_phase(input int txp, input int rxp, input bit with_pressure);
      int words;
      words = 0;
      tx_idle_pct = txp;
      rx_idle_pct = rxp;
      if (with_pressure) hold_rx = 1'b1;
      while (words < PHASE_WORDS) begin
         send_random_edge(words);
         if (with_pressure && words >= PHASE_WORDS / 2 && words < PHASE_WORDS / 2 + 26)
            drain_results();
      end
      drain_results();
   endtask

   // response side: random back-pressure and one long hold-off
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rx) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rx = 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      collapse_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (exp_q.size() == 0) begin
            $error("unexpected result tag %h", rsp.tag_out);
            fails++;
         end else begin
            e = exp_q.pop_front();
            if (rsp.tag_out !== e.tag) begin
               $error("tag_out exp %h got %h", e.tag, rsp.tag_out); fails++;
            end
            if (rsp.collapse_valid !== e.cvalid) begin
               $error("collapse_valid exp %h got %h", e.cvalid, rsp.collapse_valid); fails++;
            end
            if (rsp.keep_second !== e.keep2) begin
               $error("keep_second exp %h got %h", e.keep2, rsp.keep_second); fails++;
            end
            if (rsp.used_midpoint !== e.midp) begin
               $error("used_midpoint exp %h got %h", e.midp, rsp.used_midpoint); fails++;
            end
            if (rsp.pos_x !== e.x) begin
               $error("pos_x exp %h got %h", e.x, rsp.pos_x); fails++;
            end
            if (rsp.pos_y !== e.y) begin
               $error("pos_y exp %h got %h", e.y, rsp.pos_y); fails++;
            end
            if (rsp.pos_z !== e.z) begin
               $error("pos_z exp %h got %h", e.z, rsp.pos_z); fails++;
            end
            if (rsp.cost !== e.cost) begin
               $error("cost exp %h got %h", e.cost, rsp.cost); fails++;
            end
         end
      end
   end

   // watchdog: cycles with no request, response or register write
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req.valid <= 1'b0;
      req.edge_tag <= '0;
      req.endpoint <= 1'b0;
      req.slot <= '0;
      req.value <= '0;
      req.endpoint_locked <= 1'b0;
      req.edge_boundary <= 1'b0;
      req.last <= 1'b0;
      csr.valid <= 1'b0;
      csr.index <= '0;
      csr.data <= '0;
      foreach (acc_q[k]) acc_q[k] = 0;
      foreach (end_pos[k]) end_pos[k] = 0;
      lock_acc = 2'b00;
      bnd_acc = 1'b0;
      eps_reg = EPS_RESET;
      bnd_pen = BND_PEN_RESET;
      lck_pen = LCK_PEN_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_TAB[i]) send_word(DIR_TAB[i].w, DIR_TAB[i].typed, DIR_TAB[i].e);
      drain_results();

      write_reg(CSR_DET_EPSILON, PEN_W'(32'hFFFF_FFFF));
      write_reg(CSR_BOUNDARY_PENALTY, PEN_W'(64'd1 << 40));
      write_reg(CSR_LOCK_PENALTY, PEN_W'(64'd1 << 40));
      run_phase(27, 59, 1'b1);

      write_reg(CSR_DET_EPSILON, '0);
      write_reg(CSR_BOUNDARY_PENALTY, '0);
      write_reg(CSR_LOCK_PENALTY, '0);
      run_phase(59, 27, 1'b0);

      write_reg(CSR_DET_EPSILON, PEN_W'($urandom_range(65535)));
      write_reg(CSR_BOUNDARY_PENALTY, PEN_W'({$urandom, $urandom} & 64'hFF_FFFF_FFFF));
      write_reg(CSR_LOCK_PENALTY, PEN_W'({$urandom, $urandom} & 64'hFF_FFFF_FFFF));
      run_phase(0, 0, 1'b0);

      repeat (1000) @(posedge clock);
      if (fails == 0 && exp_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
